@@ src/bvpm_pkg.sv @@
// ----------------------------------------------------------------------------
// bvpm_pkg
// Shared types and constants of the battery voltage protection monitor.
// ----------------------------------------------------------------------------
package bvpm_pkg;

  // default sample width of the adc inputs
  localparam int unsigned ADC_BITS_DEF = 12;
  // moving average length, fixed by the shift used for the mean
  localparam int unsigned AVERAGE_TAPS = 4;
  localparam int unsigned HIST_DEPTH   = AVERAGE_TAPS - 1;

  // result field widths
  localparam int unsigned AVG_W  = 12;
  localparam int unsigned VOLT_W = 16;
  localparam int unsigned MODE_W = 2;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // ratiometric conversion: divider 100 / (100 + 681), result in tenths
  localparam int unsigned DIV_LOW    = 100;
  localparam int unsigned DIV_HIGH   = 681;
  localparam int unsigned TENTHS     = 10;
  localparam int unsigned VOLT_SCALE = (DIV_LOW + DIV_HIGH) * TENTHS;
  localparam int unsigned SCALE_W    = $clog2(VOLT_SCALE + 1);
  localparam int unsigned DIVL_W     = $clog2(DIV_LOW + 1);
  localparam logic [VOLT_W-1:0] VOLT_MAX = '1;

  // register reset values
  localparam logic [CFG_DATA_W-1:0] LOW_THR_RST  = 16'd55;
  localparam logic [CFG_DATA_W-1:0] HIGH_THR_RST = 16'd185;
  localparam logic [CFG_DATA_W-1:0] FALL_CNT_RST = 16'd20;
  localparam logic [CFG_DATA_W-1:0] RISE_CNT_RST = 16'd20;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_THR  = 2'd0,
    CFG_HIGH_THR = 2'd1,
    CFG_FALL_CNT = 2'd2,
    CFG_RISE_CNT = 2'd3
  } cfg_idx_e;

  // item kinds
  typedef enum logic {
    OP_TICK    = 1'b0,
    OP_MEASURE = 1'b1
  } op_e;

  // protection mode codes
  typedef enum logic [MODE_W-1:0] {
    MODE_INITIAL = 2'd0,
    MODE_NORMAL  = 2'd1,
    MODE_LOW     = 2'd2,
    MODE_HIGH    = 2'd3
  } mode_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_AVG,
    ST_MUL,
    ST_DIV,
    ST_CLASS,
    ST_WB
  } state_e;

  // sequencer controls to the datapath
  typedef struct packed {
    logic in_ready;
    logic tick_en;
    logic avg_en;
    logic mul_en;
    logic div_en;
    logic class_en;
    logic wb_en;
  } ctrl_t;

endpackage

@@ src/bvpm_if.sv @@
// ----------------------------------------------------------------------------
// bvpm channel interfaces
// Valid/ready channels for items, results and configuration writes.
// ----------------------------------------------------------------------------

// input item channel
interface bvpm_in_if #(
  parameter int unsigned ADC_BITS = bvpm_pkg::ADC_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic                op;
  logic                pin_level;
  logic [ADC_BITS-1:0] battery_adc;
  logic [ADC_BITS-1:0] reference_adc;

  modport source (output valid, op, pin_level, battery_adc, reference_adc, input ready);
  modport sink   (input valid, op, pin_level, battery_adc, reference_adc, output ready);
endinterface

// result item channel
interface bvpm_out_if;
  import bvpm_pkg::*;
  logic              valid;
  logic              ready;
  logic              pin_good;
  logic              shutdown_event;
  logic              fail_flag;
  logic [AVG_W-1:0]  average_adc;
  logic [VOLT_W-1:0] voltage_tenths;
  logic [MODE_W-1:0] mode;

  modport source (output valid, pin_good, shutdown_event, fail_flag, average_adc,
                  voltage_tenths, mode, input ready);
  modport sink   (input valid, pin_good, shutdown_event, fail_flag, average_adc,
                  voltage_tenths, mode, output ready);
endinterface

// configuration write channel
interface bvpm_cfg_if;
  import bvpm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/battery_voltage_protection_monitor_unit.sv @@
// ----------------------------------------------------------------------------
// battery_voltage_protection_monitor_unit
// Debounced power-good pin monitor and ratiometric battery voltage window.
// ----------------------------------------------------------------------------
// One item is in work at a time; the input is not ready from the accepting
// transfer until the result is loaded into the output register, and the
// next item can be taken while that result waits. A tick item passes through
// the accept, the debounce update and the write-back. A measurement passes
// through the accept, the four-tap average, the constant scaling, then
// ADC_BITS + 13 steps of the restoring divider that forms the quotient
// average * 7810 / (100 * reference), one quotient bit per cycle, and then
// the classification and the write-back. The write-back waits while the
// output register still holds an untaken result. A zero reference or a
// quotient above 65535 reads as 65535. Configuration writes are always
// accepted and should only be issued while no item is in work.
module battery_voltage_protection_monitor_unit #(
  parameter int unsigned ADC_BITS = bvpm_pkg::ADC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bvpm_cfg_if.sink    cfg_i,
  bvpm_in_if.sink     item_i,
  bvpm_out_if.source  result_o
);
  import bvpm_pkg::*;

  localparam int unsigned SUM_W = ADC_BITS + 2;
  localparam int unsigned NUM_W = ADC_BITS + SCALE_W;
  localparam int unsigned DEN_W = ADC_BITS + DIVL_W;
  localparam int unsigned CNT_W = $clog2(NUM_W);

  // configuration registers
  logic [CFG_DATA_W-1:0] low_thr_q, high_thr_q, fall_cnt_q, rise_cnt_q;

  // latched item
  logic                op_q, pin_q;
  logic [ADC_BITS-1:0] batt_q, ref_q;

  // debounce and protection state
  logic                  deb_started_q, deb_good_q, event_sent_q, fail_q, event_q;
  logic [CFG_DATA_W-1:0] deb_cnt_q;
  logic                  prot_started_q;
  mode_e                 mode_q;
  logic [ADC_BITS-1:0]   hist_q [HIST_DEPTH];

  // measurement datapath
  logic [ADC_BITS-1:0] avg_q;
  logic [NUM_W-1:0]    quo_q;
  logic [DEN_W-1:0]    den_q, rem_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                ref_zero_q;
  logic [VOLT_W-1:0]   volt_q;

  // output register
  logic                out_valid_q;
  logic                out_good_q, out_event_q, out_fail_q;
  logic [AVG_W-1:0]    out_avg_q;
  logic [VOLT_W-1:0]   out_volt_q;
  logic [MODE_W-1:0]   out_mode_q;

  state_e state_q, state_d;
  ctrl_t  ctrl;
  logic   out_free;

  assign out_free = !out_valid_q || result_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (item_i.valid) begin
          state_d = (item_i.op == OP_MEASURE) ? ST_AVG : ST_TICK;
        end
      end
      ST_TICK:  state_d = ST_WB;
      ST_AVG:   state_d = ST_MUL;
      ST_MUL:   state_d = ST_DIV;
      ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = ST_CLASS;
        end
      end
      ST_CLASS: state_d = ST_WB;
      ST_WB: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctrl = '0;
    case (state_q)
      ST_IDLE:  ctrl.in_ready = 1'b1;
      ST_TICK:  ctrl.tick_en  = 1'b1;
      ST_AVG:   ctrl.avg_en   = 1'b1;
      ST_MUL:   ctrl.mul_en   = 1'b1;
      ST_DIV:   ctrl.div_en   = 1'b1;
      ST_CLASS: ctrl.class_en = 1'b1;
      ST_WB:    ctrl.wb_en    = out_free;
      default:  ctrl = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign item_i.ready = ctrl.in_ready;
  assign cfg_i.ready  = 1'b1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_thr_q  <= LOW_THR_RST;
      high_thr_q <= HIGH_THR_RST;
      fall_cnt_q <= FALL_CNT_RST;
      rise_cnt_q <= RISE_CNT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_LOW_THR:  low_thr_q  <= cfg_i.data;
        CFG_HIGH_THR: high_thr_q <= cfg_i.data;
        CFG_FALL_CNT: fall_cnt_q <= cfg_i.data;
        CFG_RISE_CNT: rise_cnt_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (ctrl.in_ready && item_i.valid) begin
      op_q   <= item_i.op;
      pin_q  <= item_i.pin_level;
      batt_q <= item_i.battery_adc;
      ref_q  <= item_i.reference_adc;
    end
  end

  // debouncer and shutdown event
  logic [CFG_DATA_W-1:0] deb_limit;
  logic                  deb_good_next;
  logic [CFG_DATA_W-1:0] deb_cnt_next;

  always_comb begin
    deb_limit     = deb_good_q ? fall_cnt_q : rise_cnt_q;
    deb_good_next = deb_good_q;
    deb_cnt_next  = '0;
    if (!deb_started_q) begin
      deb_good_next = 1'b1;
    end else if (deb_cnt_q >= deb_limit) begin
      deb_good_next = !deb_good_q;
    end else if (pin_q != deb_good_q) begin
      deb_cnt_next = deb_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_started_q <= 1'b0;
      deb_good_q    <= 1'b1;
      deb_cnt_q     <= '0;
      event_sent_q  <= 1'b0;
      fail_q        <= 1'b0;
      event_q       <= 1'b0;
    end else if (ctrl.tick_en) begin
      deb_started_q <= 1'b1;
      deb_good_q    <= deb_good_next;
      deb_cnt_q     <= deb_cnt_next;
      event_q       <= !deb_good_next && !event_sent_q;
      event_sent_q  <= !deb_good_next;
      if (!deb_good_next) begin
        fail_q <= 1'b1;
      end
    end
  end

  // four-tap moving average and history shift
  logic [SUM_W-1:0] avg_sum;

  always_comb begin
    avg_sum = SUM_W'(batt_q);
    for (int i = 0; i < HIST_DEPTH; i++) begin
      avg_sum = avg_sum + SUM_W'(hist_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist_q[i] <= '0;
      end
    end else if (ctrl.avg_en) begin
      hist_q[0] <= batt_q;
      for (int i = 1; i < HIST_DEPTH; i++) begin
        hist_q[i] <= hist_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.avg_en) begin
      avg_q <= avg_sum[SUM_W-1:2];
    end
  end

  // restoring divider, one quotient bit per step
  logic [DEN_W:0] div_shift;
  logic [DEN_W:0] div_diff;
  logic           div_bit;

  assign div_shift = {rem_q, quo_q[NUM_W-1]};
  assign div_diff  = div_shift - {1'b0, den_q};
  assign div_bit   = (div_shift >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    if (ctrl.mul_en) begin
      quo_q      <= NUM_W'(avg_q) * NUM_W'(VOLT_SCALE);
      den_q      <= DEN_W'(ref_q) * DEN_W'(DIV_LOW);
      rem_q      <= '0;
      cnt_q      <= CNT_W'(NUM_W - 1);
      ref_zero_q <= (ref_q == '0);
    end else if (ctrl.div_en) begin
      rem_q <= div_bit ? div_diff[DEN_W-1:0] : div_shift[DEN_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], div_bit};
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // saturation and window classification
  logic [VOLT_W-1:0] volt_sat;
  mode_e             mode_next;

  always_comb begin
    if (ref_zero_q || (quo_q[NUM_W-1:VOLT_W] != '0)) begin
      volt_sat = VOLT_MAX;
    end else begin
      volt_sat = quo_q[VOLT_W-1:0];
    end
    if (!prot_started_q) begin
      mode_next = MODE_INITIAL;
    end else if (volt_sat > high_thr_q) begin
      mode_next = MODE_HIGH;
    end else if (deb_good_q && (volt_sat >= low_thr_q)) begin
      mode_next = MODE_NORMAL;
    end else begin
      mode_next = MODE_LOW;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prot_started_q <= 1'b0;
      mode_q         <= MODE_INITIAL;
    end else if (ctrl.class_en) begin
      prot_started_q <= 1'b1;
      mode_q         <= mode_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.class_en) begin
      volt_q <= volt_sat;
    end
  end

  // output register, freed by a result transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.wb_en) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.wb_en) begin
      out_good_q <= deb_good_q;
      out_fail_q <= fail_q;
      out_mode_q <= mode_q;
      if (op_q == OP_MEASURE) begin
        out_event_q <= 1'b0;
        out_avg_q   <= AVG_W'(avg_q);
        out_volt_q  <= volt_q;
      end else begin
        out_event_q <= event_q;
        out_avg_q   <= '0;
        out_volt_q  <= '0;
      end
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.pin_good       = out_good_q;
  assign result_o.shutdown_event = out_event_q;
  assign result_o.fail_flag      = out_fail_q;
  assign result_o.average_adc    = out_avg_q;
  assign result_o.voltage_tenths = out_volt_q;
  assign result_o.mode           = out_mode_q;

endmodule
